@@ sv/vibration_window_rms_peak_core_assert.svh @@
// Assertion macros for the vibration window core.
`ifndef VIBRATION_WINDOW_RMS_PEAK_CORE_ASSERT_SVH
`define VIBRATION_WINDOW_RMS_PEAK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define VW_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VW_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define VW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ sv/vwrp_pkg.sv @@
`timescale 1ns / 1ps
package vwrp_pkg;
  localparam int WindowDepth = 100;
  localparam int SlotW = $clog2(WindowDepth);
  localparam int FillW = $clog2(WindowDepth + 1);
  localparam int MagW = 20;

  localparam logic [0:0] RegScaleGain = 1'b0;
  localparam logic [0:0] RegStoreInterval = 1'b1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               sample_valid;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] scaled_x;
    logic signed [23:0] scaled_y;
    logic signed [23:0] scaled_z;
    logic [23:0]        magnitude;
    logic [23:0]        window_rms;
    logic [23:0]        window_peak;
    logic               store_snapshot;
  } out_word_t;
endpackage

@@ sv/vwrp_isqrt.sv @@
`timescale 1ns / 1ps
module vwrp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [49:0] radicand,
  output logic        done,
  output logic [24:0] root
);
  // Two result bits per cycle for a 50-bit radicand.
  logic [49:0] rem_r, rem_nxt;
  logic [49:0] res_r, res_nxt;
  logic [49:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    logic [49:0] v, r, b;
    v = rem_r;
    r = res_r;
    b = bit_r;
    for (int k = 0; k < 2; k++) begin
      if (b != '0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    rem_nxt = v;
    res_nxt = r;
    bit_nxt = b;
    busy_nxt = busy_r && (b != '0);
    done_nxt = busy_r && (b == '0);
    if (start) begin
      rem_nxt = radicand;
      res_nxt = '0;
      bit_nxt = 50'd1 << 48;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[24:0];
endmodule

@@ sv/vibration_window_rms_peak_core.sv @@
`timescale 1ns / 1ps
// One word in, one word out. The result waits on the walk over the window memory (one
// entry per cycle), a restoring divide of the square sum by the fill count (47 quotient
// bits), and two square roots (magnitude, RMS). A new word is taken once the previous one
// has reached the result register; while that word is held by out_stall, the next one
// waits before its scale step, so the input stalls until the result is taken.
module vibration_window_rms_peak_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vwrp_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vwrp_pkg::out_word_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import vwrp_pkg::*;
`include "vibration_window_rms_peak_core_assert.svh"

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_MAG   = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_RMS   = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r;
  logic [15:0] gain_r, intv_r, icnt_r;
  logic [SlotW-1:0] wslot_r, rd_addr_r;
  logic [FillW-1:0] fill_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [34:0] sumsq_r;
  logic [MagW-1:0] mag_r, peak_r, rms_r;
  logic [46:0] wsum_r, quo_r;
  logic [46:0] rem_r;
  logic [5:0] cnt_r;
  logic rd_pend_r;
  logic [MagW-1:0] mem [WindowDepth];
  logic [MagW-1:0] rd_data_r;
  logic sq_start, sq_done;
  logic [49:0] sq_rad;
  logic [24:0] sq_root;
  logic [1:0] sc_idx_r;
  logic out_valid_r;
  out_word_t out_r;
  logic snap_r;

  vwrp_isqrt u_isqrt (.clk, .rst_n, .start(sq_start), .radicand(sq_rad),
                      .done(sq_done), .root(sq_root));

  assign sq_start = (state_r == S_SQ && cnt_r == 6'd3) || (state_r == S_DIV && cnt_r == 6'd47);
  assign sq_rad = (state_r == S_SQ) ? {7'd0, sumsq_r, 8'd0} : {3'd0, quo_r};

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[2])
      RegScaleGain:     cfg_prdata = {16'd0, gain_r};
      RegStoreInterval: cfg_prdata = {16'd0, intv_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // scale multipliers, one shared over the axes and one over the magnitudes
  logic signed [17:0] sc_a;
  logic signed [38:0] sc_p;
  logic [35:0] sc_m;
  always_comb begin
    case (sc_idx_r)
      2'd0: sc_a = {{2{ax_r[15]}}, ax_r};
      2'd1: sc_a = {{2{ay_r[15]}}, ay_r};
      default: sc_a = {{2{az_r[15]}}, az_r};
    endcase
    sc_p = 39'(sc_a * $signed({1'b0, gain_r}));
  end

  logic [MagW-1:0] smag_sel;
  always_comb begin
    case (sc_idx_r)
      2'd0: smag_sel = mag_r;
      2'd1: smag_sel = rms_r;
      default: smag_sel = peak_r;
    endcase
    sc_m = smag_sel * gain_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) mem[wslot_r] <= mag_r;
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gain_r <= 16'd2505;
      intv_r <= 16'd100;
      icnt_r <= '0;
      wslot_r <= '0;
      fill_r <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          RegScaleGain:     gain_r <= cfg_pwdata[15:0];
          RegStoreInterval: intv_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          ax_r <= in_data.sample_valid ? in_data.accel_x : '0;
          ay_r <= in_data.sample_valid ? in_data.accel_y : '0;
          az_r <= in_data.sample_valid ? in_data.accel_z : '0;
          sumsq_r <= '0;
          cnt_r <= '0;
          sc_idx_r <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          // accumulate one axis square per cycle
          if (cnt_r < 6'd3) begin
            sumsq_r <= sumsq_r + 35'(sc_a * sc_a);
            sc_idx_r <= 2'(cnt_r + 6'd1);
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) state_r <= S_MAG;
        end
        S_MAG: if (sq_done) begin
          mag_r <= sq_root[MagW-1:0];
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          wslot_r <= (32'(wslot_r) + 1 >= WindowDepth) ? '0 : SlotW'(wslot_r + 1'b1);
          if (32'(fill_r) < WindowDepth) fill_r <= fill_r + 1'b1;
          if (32'(icnt_r) + 1 >= 32'(intv_r)) begin
            snap_r <= 1'b1;
            icnt_r <= '0;
          end else begin
            snap_r <= 1'b0;
            icnt_r <= icnt_r + 16'd1;
          end
          rd_addr_r <= '0;
          rd_pend_r <= 1'b0;
          wsum_r <= '0;
          peak_r <= '0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          // read data is registered: the accumulate uses it in the cycle after its address
          if (rd_pend_r) begin
            wsum_r <= wsum_r + 47'(rd_data_r * rd_data_r);
            if (rd_data_r > peak_r) peak_r <= rd_data_r;
          end
          if (32'(rd_addr_r) < 32'(fill_r)) begin
            rd_addr_r <= rd_addr_r + 1'b1;
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            if (!rd_pend_r) begin
              state_r <= S_DIV;
              rem_r <= '0;
              quo_r <= '0;
              cnt_r <= '0;
            end
          end
        end
        S_DIV: begin
          if (cnt_r < 6'd47) begin
            logic [47:0] t;
            t = {rem_r, wsum_r[46 - cnt_r]};
            if (t >= 48'(fill_r)) begin
              rem_r <= 47'(t - 48'(fill_r));
              quo_r <= {quo_r[45:0], 1'b1};
            end else begin
              rem_r <= t[46:0];
              quo_r <= {quo_r[45:0], 1'b0};
            end
            cnt_r <= cnt_r + 6'd1;
          end else begin
            state_r <= S_RMS;
          end
        end
        S_RMS: if (sq_done) begin
          rms_r <= sq_root[MagW-1:0];
          sc_idx_r <= '0;
          state_r <= S_SCALE;
        end
        // hold while the last result word is stalled
        S_SCALE: if (!out_valid_r || !out_stall) begin
          out_r.scaled_x <= (sc_idx_r == 2'd0) ? 24'(sc_p >>> 8) : out_r.scaled_x;
          out_r.scaled_y <= (sc_idx_r == 2'd1) ? 24'(sc_p >>> 8) : out_r.scaled_y;
          out_r.scaled_z <= (sc_idx_r == 2'd2) ? 24'(sc_p >>> 8) : out_r.scaled_z;
          out_r.magnitude <= (sc_idx_r == 2'd0) ? sc_m[35:12] : out_r.magnitude;
          out_r.window_rms <= (sc_idx_r == 2'd1) ? sc_m[35:12] : out_r.window_rms;
          out_r.window_peak <= (sc_idx_r == 2'd2) ? sc_m[35:12] : out_r.window_peak;
          out_r.store_snapshot <= snap_r;
          sc_idx_r <= sc_idx_r + 2'd1;
          if (sc_idx_r == 2'd2) state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || !out_stall) begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result word changed under stall")
  `VW_ASSERT_IMPL(a_fill_range, clk, rst_n, 32'(fill_r) <= WindowDepth, "fill count beyond window depth")
  `VW_ASSERT_IMPL(a_take_idle, clk, rst_n, !(in_valid && !in_stall) || state_r == S_IDLE, "word taken while busy")
endmodule
